/* sv/tli_pkg.sv */
// Shared constants, codes and types of the table linear interpolator.
package tli_pkg;

   // Table size and fraction precision.
   localparam int TABLE_DEPTH   = 256;
   localparam int FRACTION_BITS = 16;

   // Derived widths.
   localparam int DATA_W = 32;
   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int QUO_W  = FRACTION_BITS + 1;
   localparam int STEP_W = $clog2(QUO_W);
   localparam int DIFF_W = DATA_W + 1;
   localparam int PROD_W = QUO_W + 1 + DIFF_W;
   localparam int SUM_W  = PROD_W - FRACTION_BITS + 1;

   // Operation codes.
   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   // Status codes.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_CLAMPED = 2'd1;
   localparam logic [1:0] ST_EMPTY   = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   // Saturation limits of a result.
   localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
   localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

   // Table write port.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] energy;
      logic [DATA_W-1:0] intensity;
   } mem_wr_type;

   // Divider result.
   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_res_type;

endpackage

/* sv/tli_table_mem.sv */
// Point table: energy and intensity memories with one write and one registered read port.
module tli_table_mem (
   input  logic                             clock,
   input  tli_pkg::mem_wr_type              wr,
   input  logic                             rd_en,
   input  logic [tli_pkg::ADDR_W-1:0]       rd_addr,
   output logic signed [tli_pkg::DATA_W-1:0] rd_energy,
   output logic signed [tli_pkg::DATA_W-1:0] rd_intensity
);

   logic [tli_pkg::DATA_W-1:0] energy_mem_ff    [tli_pkg::TABLE_DEPTH];
   logic [tli_pkg::DATA_W-1:0] intensity_mem_ff [tli_pkg::TABLE_DEPTH];
   logic [tli_pkg::DATA_W-1:0] rd_energy_ff;
   logic [tli_pkg::DATA_W-1:0] rd_intensity_ff;

   // Write one point per cycle.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         energy_mem_ff[wr.addr]    <= wr.energy;
         intensity_mem_ff[wr.addr] <= wr.intensity;
      end
   end

   // Registered read; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_energy_ff    <= energy_mem_ff[rd_addr];
         rd_intensity_ff <= intensity_mem_ff[rd_addr];
      end
   end

   assign rd_energy    = $signed(rd_energy_ff);
   assign rd_intensity = $signed(rd_intensity_ff);

endmodule

/* sv/tli_divider.sv */
// Restoring divider that produces the segment fraction one quotient bit per cycle.
module tli_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tli_pkg::DATA_W-1:0]  num,
   input  logic [tli_pkg::DATA_W-1:0]  den,
   output tli_pkg::div_res_type        res
);

   logic                        busy_ff,  busy_in;
   logic                        done_ff,  done_in;
   logic [tli_pkg::STEP_W-1:0]  step_ff,  step_in;
   logic [tli_pkg::DATA_W:0]    rem_ff,   rem_in;
   logic [tli_pkg::DATA_W-1:0]  den_ff,   den_in;
   logic [tli_pkg::QUO_W-1:0]   quo_ff,   quo_in;
   logic                        bit_q;
   logic [tli_pkg::DATA_W:0]    diff;

   // The first step weighs the whole numerator against the divisor. The user must keep
   // the numerator from exceeding the divisor; the divider does not enforce this.
   always_comb begin
      bit_q   = (rem_ff >= {1'b0, den_ff});
      diff    = bit_q ? (rem_ff - {1'b0, den_ff}) : rem_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = tli_pkg::STEP_W'(tli_pkg::QUO_W - 1);
         rem_in  = {1'b0, num};
         den_in  = den;
         quo_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[tli_pkg::QUO_W-2:0], bit_q};
         rem_in = {diff[tli_pkg::DATA_W-1:0], 1'b0};
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
   end

   assign res.done     = done_ff;
   assign res.quotient = quo_ff;

endmodule

/* sv/table_linear_interpolator_top.sv */
// Top level of the table linear interpolator: sequencer, search, blend and result register.
// Items are taken one at a time. A clear, an append or an unused operation registers its
// result and goes to the reply state, which loads it into the output register once that is
// free. A query walks the point table through its single read port: it reads the first
// point, then the last, halves the bracket once per read (up to eight halvings for a full
// table of 256 points), reads the two segment ends, waits while the bit-serial divider
// forms its seventeen quotient bits and flags completion, then multiplies, does the
// saturating add and hands the result over; a lone point or a query that clamps answers
// after the first or last read. A result that the receiver holds off stalls the next one.
// The table needs no clearing pass after reset, because only points appended since the last
// clear are ever read.
module table_linear_interpolator_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_operation,
   input  logic signed [tli_pkg::DATA_W-1:0] req_point_energy,
   input  logic signed [tli_pkg::DATA_W-1:0] req_point_intensity,
   input  logic signed [tli_pkg::DATA_W-1:0] req_query_energy,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [tli_pkg::DATA_W-1:0] rsp_intensity,
   output logic [1:0]                        rsp_status
);

   // Sequencer states.
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_FIRST  = 4'd1;
   localparam logic [3:0] S_LAST   = 4'd2;
   localparam logic [3:0] S_SEARCH = 4'd3;
   localparam logic [3:0] S_LO     = 4'd4;
   localparam logic [3:0] S_HI     = 4'd5;
   localparam logic [3:0] S_DIV    = 4'd6;
   localparam logic [3:0] S_MUL    = 4'd7;
   localparam logic [3:0] S_SUM    = 4'd8;
   localparam logic [3:0] S_REPLY  = 4'd9;

   localparam logic [tli_pkg::QUO_W-1:0] T_ONE =
      tli_pkg::QUO_W'(1) << tli_pkg::FRACTION_BITS;

   logic [3:0]                          state_ff, state_in;
   logic [tli_pkg::CNT_W-1:0]           count_ff, count_in;
   logic signed [tli_pkg::DATA_W-1:0]   query_ff, query_in;
   logic [tli_pkg::ADDR_W-1:0]          lo_ff,    lo_in;
   logic [tli_pkg::ADDR_W-1:0]          hi_ff,    hi_in;
   logic [tli_pkg::ADDR_W-1:0]          mid_ff,   mid_in;
   logic signed [tli_pkg::DATA_W-1:0]   e_lo_ff,  e_lo_in;
   logic signed [tli_pkg::DATA_W-1:0]   i_lo_ff,  i_lo_in;
   logic signed [tli_pkg::DIFF_W-1:0]   di_ff,    di_in;
   logic [tli_pkg::QUO_W-1:0]           t_ff,     t_in;
   logic signed [tli_pkg::PROD_W-1:0]   prod_ff,  prod_in;
   logic signed [tli_pkg::DATA_W-1:0]   res_ff,   res_in;
   logic [1:0]                          stat_ff,  stat_in;
   logic                                rsp_valid_ff,     rsp_valid_in;
   logic signed [tli_pkg::DATA_W-1:0]   rsp_intensity_ff, rsp_intensity_in;
   logic [1:0]                          rsp_status_ff,    rsp_status_in;

   tli_pkg::mem_wr_type                 mem_wr;
   logic                                rd_en;
   logic [tli_pkg::ADDR_W-1:0]          rd_addr;
   logic signed [tli_pkg::DATA_W-1:0]   rd_energy;
   logic signed [tli_pkg::DATA_W-1:0]   rd_intensity;
   logic                                div_start;
   logic [tli_pkg::DATA_W-1:0]          div_num;
   logic [tli_pkg::DATA_W-1:0]          div_den;
   tli_pkg::div_res_type                div_res;

   logic                                accept;
   logic [tli_pkg::ADDR_W-1:0]          last_idx;
   logic [tli_pkg::ADDR_W-1:0]          lo_n;
   logic [tli_pkg::ADDR_W-1:0]          hi_n;
   logic [tli_pkg::ADDR_W-1:0]          span;
   logic                                walk;
   logic signed [tli_pkg::DIFF_W-1:0]   e_diff_q;
   logic signed [tli_pkg::DIFF_W-1:0]   e_diff_seg;
   logic signed [tli_pkg::PROD_W-tli_pkg::FRACTION_BITS-1:0] step;
   logic signed [tli_pkg::SUM_W-1:0]    sum;
   logic [tli_pkg::SUM_W-tli_pkg::DATA_W:0] sum_top;

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign last_idx = tli_pkg::ADDR_W'(count_ff - 1'b1);

   // Segment arithmetic: energy offsets and the floored, saturated blend.
   always_comb begin
      e_diff_q   = tli_pkg::DIFF_W'(query_ff) - tli_pkg::DIFF_W'(e_lo_ff);
      e_diff_seg = tli_pkg::DIFF_W'(rd_energy) - tli_pkg::DIFF_W'(e_lo_ff);
      step       = prod_ff[tli_pkg::PROD_W-1:tli_pkg::FRACTION_BITS];
      sum        = tli_pkg::SUM_W'(i_lo_ff) + tli_pkg::SUM_W'(step);
      sum_top    = sum[tli_pkg::SUM_W-1:tli_pkg::DATA_W-1];
   end

   // Sequencer and next-state logic.
   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      query_in         = query_ff;
      lo_in            = lo_ff;
      hi_in            = hi_ff;
      mid_in           = mid_ff;
      e_lo_in          = e_lo_ff;
      i_lo_in          = i_lo_ff;
      di_in            = di_ff;
      t_in             = t_ff;
      prod_in          = prod_ff;
      res_in           = res_ff;
      stat_in          = stat_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_intensity_in = rsp_intensity_ff;
      rsp_status_in    = rsp_status_ff;
      mem_wr.en        = 1'b0;
      mem_wr.addr      = count_ff[tli_pkg::ADDR_W-1:0];
      mem_wr.energy    = req_point_energy;
      mem_wr.intensity = req_point_intensity;
      rd_en            = 1'b0;
      rd_addr          = '0;
      div_start        = 1'b0;
      div_num          = e_diff_q[tli_pkg::DATA_W-1:0];
      div_den          = e_diff_seg[tli_pkg::DATA_W-1:0];
      lo_n             = lo_ff;
      hi_n             = hi_ff;
      walk             = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_in   = '0;
               stat_in  = tli_pkg::ST_OK;
               state_in = S_REPLY;
               case (req_operation)
                  tli_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  tli_pkg::OP_APPEND: begin
                     if (count_ff >= tli_pkg::CNT_W'(tli_pkg::TABLE_DEPTH)) begin
                        stat_in = tli_pkg::ST_FULL;
                     end else begin
                        mem_wr.en = 1'b1;
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  tli_pkg::OP_QUERY: begin
                     query_in = req_query_energy;
                     if (count_ff == '0) begin
                        stat_in = tli_pkg::ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        state_in = S_FIRST;
                     end
                  end
                  default: begin
                     stat_in = tli_pkg::ST_OK;
                  end
               endcase
            end
         end

         // First point: a lone point answers for itself, and queries at or below it clamp.
         S_FIRST: begin
            if (count_ff == tli_pkg::CNT_W'(1)) begin
               res_in   = rd_intensity;
               state_in = S_REPLY;
            end else if (query_ff <= rd_energy) begin
               res_in   = rd_intensity;
               stat_in  = tli_pkg::ST_CLAMPED;
               state_in = S_REPLY;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = last_idx;
               state_in = S_LAST;
            end
         end

         // Last point: queries at or above it take its intensity.
         S_LAST: begin
            if (query_ff >= rd_energy) begin
               res_in   = rd_intensity;
               stat_in  = (query_ff > rd_energy) ? tli_pkg::ST_CLAMPED : tli_pkg::ST_OK;
               state_in = S_REPLY;
            end else begin
               lo_n = '0;
               hi_n = last_idx;
               walk = 1'b1;
            end
         end

         // One halving of the bracket per memory read.
         S_SEARCH: begin
            if (query_ff <= rd_energy) begin
               hi_n = mid_ff;
            end else begin
               lo_n = mid_ff;
            end
            walk = 1'b1;
         end

         // Lower end of the segment.
         S_LO: begin
            e_lo_in  = rd_energy;
            i_lo_in  = rd_intensity;
            rd_en    = 1'b1;
            rd_addr  = hi_ff;
            state_in = S_HI;
         end

         // Upper end: a flat or falling segment gives the lower intensity.
         S_HI: begin
            if (rd_energy <= e_lo_ff) begin
               res_in   = i_lo_ff;
               state_in = S_REPLY;
            end else begin
               div_start = 1'b1;
               di_in     = tli_pkg::DIFF_W'(rd_intensity) - tli_pkg::DIFF_W'(i_lo_ff);
               state_in  = S_DIV;
            end
         end

         S_DIV: begin
            if (div_res.done) begin
               t_in     = (div_res.quotient > T_ONE) ? T_ONE : div_res.quotient;
               state_in = S_MUL;
            end
         end

         S_MUL: begin
            prod_in  = $signed({1'b0, t_ff}) * di_ff;
            state_in = S_SUM;
         end

         // Floor of the scaled step, added to the lower intensity with saturation.
         S_SUM: begin
            if ((&sum_top) || !(|sum_top)) begin
               res_in = sum[tli_pkg::DATA_W-1:0];
            end else begin
               res_in = sum[tli_pkg::SUM_W-1] ? tli_pkg::DATA_MIN : tli_pkg::DATA_MAX;
            end
            state_in = S_REPLY;
         end

         // Hand the result over once the output register is free.
         S_REPLY: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in     = 1'b1;
               rsp_intensity_in = res_ff;
               rsp_status_in    = stat_ff;
               state_in         = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Either probe the middle of the bracket or fetch the segment that it has closed on.
      span = hi_n - lo_n;
      if (walk) begin
         lo_in = lo_n;
         hi_in = hi_n;
         rd_en = 1'b1;
         if (span > tli_pkg::ADDR_W'(1)) begin
            mid_in   = lo_n + (span >> 1);
            rd_addr  = lo_n + (span >> 1);
            state_in = S_SEARCH;
         end else begin
            rd_addr  = lo_n;
            state_in = S_LO;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      query_ff         <= query_in;
      lo_ff            <= lo_in;
      hi_ff            <= hi_in;
      mid_ff           <= mid_in;
      e_lo_ff          <= e_lo_in;
      i_lo_ff          <= i_lo_in;
      di_ff            <= di_in;
      t_ff             <= t_in;
      prod_ff          <= prod_in;
      res_ff           <= res_in;
      stat_ff          <= stat_in;
      rsp_intensity_ff <= rsp_intensity_in;
      rsp_status_ff    <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_intensity = rsp_intensity_ff;
   assign rsp_status    = rsp_status_ff;

   // Point table.
   tli_table_mem u_table (
      .clock        (clock),
      .wr           (mem_wr),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_energy    (rd_energy),
      .rd_intensity (rd_intensity)
   );

   // Fraction divider.
   tli_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .res   (div_res)
   );

endmodule

/* sv/tli_checker.sv */
// Port-level checks of the table linear interpolator and their binding to the top level.
module tli_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic [1:0]                        req_operation,
   input logic signed [tli_pkg::DATA_W-1:0] req_point_energy,
   input logic signed [tli_pkg::DATA_W-1:0] req_point_intensity,
   input logic signed [tli_pkg::DATA_W-1:0] req_query_energy,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [tli_pkg::DATA_W-1:0] rsp_intensity,
   input logic [1:0]                        rsp_status
);

   // A result that is held back keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_intensity) && $stable(rsp_status))
      else $error("stalled result changed");

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Only one item is in work at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item accepted while busy");

   // Empty-table and full-table answers carry no intensity.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == tli_pkg::ST_EMPTY || rsp_status == tli_pkg::ST_FULL)
      |-> rsp_intensity == '0)
      else $error("non-zero intensity with empty or full status");

endmodule

bind table_linear_interpolator_top tli_checker u_checker (.*);

/* sim/tb_table_linear_interpolator_top.sv */
// Self-checking testbench for the table linear interpolator top level.
`timescale 1ns / 1ps

module tb_table_linear_interpolator_top;

   // The operation code that the block leaves unused.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // A full-table query, the longest idle gap and the long receiver hold-off all end well
   // within this limit, so this many silent cycles means a hang.
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int ITEM_TARGET = 1650;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      logic signed [tli_pkg::DATA_W-1:0] intensity;
      logic [1:0]                        status;
      int                                seq_no;
   } interp_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_operation = tli_pkg::OP_CLEAR;
   logic signed [tli_pkg::DATA_W-1:0] req_point_energy = '0;
   logic signed [tli_pkg::DATA_W-1:0] req_point_intensity = '0;
   logic signed [tli_pkg::DATA_W-1:0] req_query_energy = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [tli_pkg::DATA_W-1:0] rsp_intensity;
   logic [1:0] rsp_status;

   // Predictor copy of the point table.
   logic signed [tli_pkg::DATA_W-1:0] energy_tbl [tli_pkg::TABLE_DEPTH];
   logic signed [tli_pkg::DATA_W-1:0] intensity_tbl [tli_pkg::TABLE_DEPTH];
   int point_count = 0;

   interp_result_type expected_results[$];
   int items_sent = 0;
   int mismatches = 0;
   int results_seen = 0;
   int clamped_seen = 0;
   int empty_seen = 0;
   int full_seen = 0;
   int idle_cycles = 0;
   int hold_off_request = 0;
   bit idling_on = 1'b1;

   table_linear_interpolator_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_point_energy    (req_point_energy),
      .req_point_intensity (req_point_intensity),
      .req_query_energy    (req_query_energy),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_intensity       (rsp_intensity),
      .rsp_status          (rsp_status)
   );

   // Free-running clock, 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Works out the result of one item and updates the predicted table.
   function automatic interp_result_type interp_predict(
         input logic [1:0] op,
         input logic signed [tli_pkg::DATA_W-1:0] pe,
         input logic signed [tli_pkg::DATA_W-1:0] pi,
         input logic signed [tli_pkg::DATA_W-1:0] q);
      interp_result_type r;
      int lo, hi, mid;
      longint e0, e1, i0, i1, prod, step, sum;
      longint unsigned num, den, frac, mag;
      r.intensity = '0;
      r.status = tli_pkg::ST_OK;
      r.seq_no = items_sent;
      case (op)
         tli_pkg::OP_CLEAR: begin
            point_count = 0;
         end
         tli_pkg::OP_APPEND: begin
            if (point_count >= tli_pkg::TABLE_DEPTH) begin
               r.status = tli_pkg::ST_FULL;
            end else begin
               energy_tbl[point_count] = pe;
               intensity_tbl[point_count] = pi;
               point_count++;
            end
         end
         tli_pkg::OP_QUERY: begin
            if (point_count == 0) begin
               r.status = tli_pkg::ST_EMPTY;
            end else if (point_count == 1) begin
               r.intensity = intensity_tbl[0];
            end else if (q <= energy_tbl[0]) begin
               r.intensity = intensity_tbl[0];
               r.status = tli_pkg::ST_CLAMPED;
            end else if (q >= energy_tbl[point_count-1]) begin
               r.intensity = intensity_tbl[point_count-1];
               if (q > energy_tbl[point_count-1]) r.status = tli_pkg::ST_CLAMPED;
            end else begin
               // Binary search for the upper point of the bracketing segment.
               lo = 0;
               hi = point_count - 1;
               while (hi - lo > 1) begin
                  mid = lo + (hi - lo) / 2;
                  if (q <= energy_tbl[mid]) hi = mid;
                  else lo = mid;
               end
               e0 = energy_tbl[hi-1];
               e1 = energy_tbl[hi];
               i0 = intensity_tbl[hi-1];
               i1 = intensity_tbl[hi];
               if (e1 <= e0) begin
                  r.intensity = intensity_tbl[hi-1];
               end else begin
                  // Fraction within the segment, then a blend rounded towards minus infinity.
                  num = longint'(q) - e0;
                  den = e1 - e0;
                  frac = (num << tli_pkg::FRACTION_BITS) / den;
                  if (frac > (64'd1 << tli_pkg::FRACTION_BITS))
                     frac = 64'd1 << tli_pkg::FRACTION_BITS;
                  prod = longint'(frac) * (i1 - i0);
                  if (prod >= 0) begin
                     step = prod >>> tli_pkg::FRACTION_BITS;
                  end else begin
                     mag = longint'(-prod) + ((64'd1 << tli_pkg::FRACTION_BITS) - 64'd1);
                     step = -longint'(mag >> tli_pkg::FRACTION_BITS);
                  end
                  sum = i0 + step;
                  if (sum > longint'(tli_pkg::DATA_MAX)) sum = longint'(tli_pkg::DATA_MAX);
                  if (sum < longint'(tli_pkg::DATA_MIN)) sum = longint'(tli_pkg::DATA_MIN);
                  r.intensity = sum[tli_pkg::DATA_W-1:0];
               end
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // Idle gap length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   // Offers one item, holds it until accepted and records its expected result.
   // Entered and left at a falling edge.
   task automatic send_item(input logic [1:0] op, input logic [tli_pkg::DATA_W-1:0] pe,
                            input logic [tli_pkg::DATA_W-1:0] pi,
                            input logic [tli_pkg::DATA_W-1:0] q);
      int gap;
      interp_result_type r;
      gap = idling_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_point_energy <= pe;
      req_point_intensity <= pi;
      req_query_energy <= q;
      do @(posedge clock); while (req_stall !== 1'b0);
      r = interp_predict(op, pe, pi, q);
      expected_results.push_back(r);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic clear_table();
      send_item(tli_pkg::OP_CLEAR, $urandom, $urandom, $urandom);
   endtask

   task automatic append_point(input logic [tli_pkg::DATA_W-1:0] e,
                               input logic [tli_pkg::DATA_W-1:0] i);
      send_item(tli_pkg::OP_APPEND, e, i, $urandom);
   endtask

   task automatic query_at(input logic [tli_pkg::DATA_W-1:0] q);
      send_item(tli_pkg::OP_QUERY, $urandom, $urandom, q);
   endtask

   // Appends n points in ascending energy order, either spread over the whole range or
   // clustered with small steps, some of them zero.
   task automatic load_sorted_points(input int n, input bit clustered);
      longint cur, step_max;
      longint unsigned rnd;
      int k;
      if (clustered) cur = longint'($signed($urandom)) >>> 1;
      else cur = longint'(tli_pkg::DATA_MIN) + longint'($urandom_range(0, 1000));
      for (k = 0; k < n; k++) begin
         append_point(cur[tli_pkg::DATA_W-1:0], $urandom);
         if (clustered) step_max = longint'(1) << $urandom_range(0, 22);
         else step_max = (longint'(1) << 33) / n;
         rnd = $urandom;
         cur += longint'((rnd * longint'(step_max)) >> 32);
         if (cur > longint'(tli_pkg::DATA_MAX)) cur = longint'(tli_pkg::DATA_MAX);
      end
   endtask

   // Queries at a point, inside a segment, just outside the ends, or anywhere at all.
   task automatic query_near_table();
      longint qv, lo_e, hi_e;
      longint unsigned rnd;
      int k, pick;
      pick = $urandom_range(99);
      rnd = $urandom;
      if (point_count < 2 || pick < 10) begin
         qv = longint'($signed($urandom));
      end else begin
         k = $urandom_range(0, point_count - 2);
         lo_e = energy_tbl[k];
         hi_e = energy_tbl[k+1];
         if (pick < 25) qv = energy_tbl[k + $urandom_range(0, 1)];
         else if (pick < 32)
            qv = longint'(energy_tbl[0]) - longint'($urandom_range(0, 65536));
         else if (pick < 39)
            qv = longint'(energy_tbl[point_count-1]) + longint'($urandom_range(0, 65536));
         else if (hi_e > lo_e)
            qv = lo_e + 1 + longint'((rnd * longint'(hi_e - lo_e - 1)) >> 32);
         else qv = lo_e;
      end
      if (qv > longint'(tli_pkg::DATA_MAX)) qv = longint'(tli_pkg::DATA_MAX);
      if (qv < longint'(tli_pkg::DATA_MIN)) qv = longint'(tli_pkg::DATA_MIN);
      query_at(qv[tli_pkg::DATA_W-1:0]);
   endtask

   // Withdraws the offer, waits until every expected result has come, then lets the block
   // settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Extremes of the fields, every operation and the special cases of the search.
   task automatic test_directed_cases();
      query_at(32'sd0);
      send_item(OP_UNUSED, tli_pkg::DATA_MAX, tli_pkg::DATA_MIN, tli_pkg::DATA_MAX);
      append_point(tli_pkg::DATA_MIN, tli_pkg::DATA_MAX);
      query_at(tli_pkg::DATA_MAX);
      query_at(tli_pkg::DATA_MIN);
      // A duplicate energy gives a zero-width segment in the middle of the table.
      append_point(32'sd0, tli_pkg::DATA_MIN);
      append_point(32'sd0, 32'sd5);
      append_point(tli_pkg::DATA_MAX, 32'sh0000_1234);
      query_at(tli_pkg::DATA_MIN);
      query_at(tli_pkg::DATA_MIN + 32'sd1);
      query_at(-32'sd1);
      query_at(32'sd0);
      query_at(32'sd1);
      query_at(tli_pkg::DATA_MAX);
      clear_table();
      query_at(32'sd0);
      // Points appended out of order.
      append_point(32'sh0064_0000, 32'sh000A_0000);
      append_point(32'sh0032_0000, 32'sh0014_0000);
      append_point(32'sh00C8_0000, -32'sh001E_0000);
      query_at(32'sh003C_0000);
      query_at(32'sh0096_0000);
      query_at(32'sh012C_0000);
      query_at(32'sh0064_0000);
      query_at(32'sd0);
   endtask

   // A full table: deepest search, rejected appends and an unused operation while full.
   task automatic test_full_table();
      clear_table();
      load_sorted_points(tli_pkg::TABLE_DEPTH, 1'b0);
      repeat (3) append_point($urandom, $urandom);
      send_item(OP_UNUSED, $urandom, $urandom, $urandom);
      query_at(energy_tbl[0]);
      query_at(energy_tbl[tli_pkg::TABLE_DEPTH-1]);
      repeat (40) query_near_table();
   endtask

   // The receiver holds off for a long stretch so that the block fills and stalls its
   // input, then the sender pauses until the block has drained.
   task automatic test_backpressure();
      clear_table();
      load_sorted_points(12, 1'b1);
      hold_off_request = HOLD_OFF_CYCLES;
      repeat (20) query_near_table();
      wait_drained();
      repeat (10) query_near_table();
   endtask

   // Well-formed load-then-query sequences with random content, mixed with noise.
   task automatic test_random_sequences();
      int r, n, m;
      while (items_sent < ITEM_TARGET) begin
         idling_on = ($urandom_range(9) != 0);
         if ($urandom_range(9) != 0) clear_table();
         r = $urandom_range(99);
         if (r < 70) n = $urandom_range(2, 8);
         else if (r < 88) n = $urandom_range(9, 40);
         else if (r < 95) n = $urandom_range(0, 1);
         else n = $urandom_range(100, tli_pkg::TABLE_DEPTH);
         load_sorted_points(n, $urandom_range(1) == 1);
         if ($urandom_range(99) < 15)
            repeat ($urandom_range(1, 3)) append_point($urandom, $urandom);
         m = $urandom_range(3, 20);
         repeat (m) begin
            if ($urandom_range(99) < 8)
               send_item(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
            else query_near_table();
         end
      end
      idling_on = 1'b1;
   endtask

   // Receiver stall: random gaps, or a long hold-off when a test asks for one.
   initial begin : rsp_stall_driver
      int len;
      forever begin
         @(negedge clock);
         if (hold_off_request > 0) begin
            len = hold_off_request;
            hold_off_request = 0;
            rsp_stall <= 1'b1;
            repeat (len) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (idling_on && $urandom_range(2) == 0) begin
            len = pick_gap();
            if (len > 0) begin
               rsp_stall <= 1'b1;
               repeat (len) @(negedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Compares each accepted result with the oldest expectation.
   always @(posedge clock) begin : result_checker
      interp_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: intensity %0d status %0d",
                                      rsp_intensity, rsp_status));
         end else begin
            want = expected_results.pop_front();
            results_seen++;
            if (want.status == tli_pkg::ST_CLAMPED) clamped_seen++;
            if (want.status == tli_pkg::ST_EMPTY) empty_seen++;
            if (want.status == tli_pkg::ST_FULL) full_seen++;
            if (rsp_intensity !== want.intensity || rsp_status !== want.status)
               report_mismatch($sformatf(
                  "item %0d: intensity exp %0d got %0d, status exp %0d got %0d",
                  want.seq_no, want.intensity, rsp_intensity, want.status, rsp_status));
         end
      end
   end

   // Ends the run if no item moves on either channel for too long.
   always @(posedge clock) begin : watchdog
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d results outstanding", expected_results.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // Test sequence.
   initial begin : test_sequence
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_cases();
      test_full_table();
      test_backpressure();
      test_random_sequences();
      wait_drained();
      if (expected_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
      $display("Run covered %0d items and %0d results, with tables from empty to full depth,",
               items_sent, results_seen);
      $display("%0d clamped, %0d empty and %0d full answers, under random stalls on both sides.",
               clamped_seen, empty_seen, full_seen);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches in total", mismatches);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* table_linear_interpolator_top.f */
sv/tli_pkg.sv
sv/tli_table_mem.sv
sv/tli_divider.sv
sv/table_linear_interpolator_top.sv
sv/tli_checker.sv
sim/tb_table_linear_interpolator_top.sv
